FILE: hdl/esd_pkg.sv
package esd_pkg;

    localparam int TIME_BITS = 32;
    localparam int MAX_TOKS  = 3;
    localparam int CNTW      = $clog2(MAX_TOKS + 1);
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int MS_PER_S  = 1000;
    localparam int DEC_BASE  = 10;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // token kinds
    localparam logic [2:0] K_CHAR  = 3'd0;
    localparam logic [2:0] K_END   = 3'd1;
    localparam logic [2:0] K_SEND  = 3'd2;
    localparam logic [2:0] K_DELAY = 3'd3;
    localparam logic [2:0] K_WAIT  = 3'd4;

    typedef logic [TIME_BITS-1:0]    t_time;
    typedef logic [TIME_BITS+9:0]    t_prod;
    typedef logic [TIME_BITS+3:0]    t_tacc;
    typedef logic [CNTW-1:0]         t_cnt;
    typedef logic [QAW-1:0]          t_qptr;
    typedef logic [QAW:0]            t_qcnt;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        t_time      tm;
        logic       scale;
    } t_tok;

    typedef struct packed {
        t_cnt                  cnt;
        t_tok [MAX_TOKS-1:0]   toks;
    } t_bundle;

    function automatic t_tok mk_tok(logic [2:0] kind, logic [7:0] ch, t_time tm, logic scale);
        t_tok t;
        t.kind  = kind;
        t.ch    = ch;
        t.tm    = tm;
        t.scale = scale;
        return t;
    endfunction

    // seconds to milliseconds, saturating
    function automatic t_time scale_ms(t_time v);
        t_prod prod;
        prod = t_prod'(v) * t_prod'(MS_PER_S);
        if (prod > t_prod'(TIME_MAX)) begin
            return TIME_MAX;
        end
        return prod[TIME_BITS-1:0];
    endfunction

endpackage

FILE: hdl/escape_sequence_decoder.sv
// Escape sequence decoder: turns a command-script byte stream into tokens.
// Input side is a queue write port: a byte transfers on a rising edge with
// push high and full low; i_is_last marks the final byte of a string.
// Result side is a queue read port: while empty is low the oldest token is
// on o_kind/o_char_value/o_millis/o_last_of_run, and it transfers on an
// edge with pop high. o_last_of_run flags the final token caused by a byte.
// A byte is parsed in the cycle it transfers and its 0 to 3 tokens enter a
// 4-entry bundle queue; while pop is high the back end hands out one token
// per cycle, from its bundle register into its output register. One byte is
// taken every cycle while pop is high and bytes average at most one token
// each; the back end's single output register sets that bound.
// Synchronous reset empties the queue and back end and idles the parser.
// When pop stays low the output holds, the bundle queue fills, and full
// rises once the queue holds 4 bundles with a fifth parked in the back end.
module escape_sequence_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_byte_in,
    input  logic        i_is_last,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_char_value,
    output logic [31:0] o_millis,
    output logic        o_last_of_run
);

    esd_pkg::t_bundle fr_bnd;
    esd_pkg::t_bundle q_bnd;
    logic             accept;
    logic             q_valid;
    logic             q_take;

    assign accept = push && !full;

    esd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_byte_in),
        .i_last   (i_is_last),
        .o_bundle (fr_bnd)
    );

    esd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && (fr_bnd.cnt != '0)),
        .i_data  (fr_bnd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_bnd),
        .i_pop   (q_take)
    );

    esd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bnd_valid   (q_valid),
        .i_bnd         (q_bnd),
        .o_bnd_take    (q_take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_kind        (o_kind),
        .o_char_value  (o_char_value),
        .o_millis      (o_millis),
        .o_last_of_run (o_last_of_run)
    );

endmodule

FILE: hdl/esd_front.sv
module esd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output esd_pkg::t_bundle o_bundle
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_ESC  = 3'd1;
    localparam logic [2:0] M_HEX0 = 3'd2;
    localparam logic [2:0] M_HEX1 = 3'd3;
    localparam logic [2:0] M_OCT  = 3'd4;
    localparam logic [2:0] M_TIME = 3'd5;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_A   = 8'h61;
    localparam logic [7:0] CH_B   = 8'h62;
    localparam logic [7:0] CH_F   = 8'h66;
    localparam logic [7:0] CH_N   = 8'h6E;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_V   = 8'h76;
    localparam logic [7:0] CH_X   = 8'h78;
    localparam logic [7:0] CH_S   = 8'h73;
    localparam logic [7:0] CH_D   = 8'h64;
    localparam logic [7:0] CH_W   = 8'h77;
    localparam logic [7:0] CH_M   = 8'h6D;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_7   = 8'h37;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;

    localparam logic [7:0] C_BEL = 8'd7;
    localparam logic [7:0] C_BS  = 8'd8;
    localparam logic [7:0] C_FF  = 8'd12;
    localparam logic [7:0] C_LF  = 8'd10;
    localparam logic [7:0] C_CR  = 8'd13;
    localparam logic [7:0] C_HT  = 8'd9;
    localparam logic [7:0] C_VT  = 8'd11;

    logic [2:0]     r_mode, n_mode;
    logic [8:0]     r_digit, n_digit;
    logic [1:0]     r_dcount, n_dcount;
    esd_pkg::t_time r_time, n_time;
    logic           r_wait, n_wait;

    esd_pkg::t_bundle bnd;
    esd_pkg::t_tacc   tacc;
    logic             ended;
    logic             rescan;
    logic             clr;
    logic             hex_ok;
    logic [3:0]       hex_v;
    logic             is_oct;
    logic             is_dec;
    logic [8:0]       oct_acc;

    always_comb begin
        hex_ok = 1'b1;
        hex_v  = '0;
        if (i_byte >= CH_0 && i_byte <= CH_9) begin
            hex_v = i_byte[3:0];
        end else if ((i_byte >= CH_UA && i_byte <= CH_UF) || (i_byte >= CH_A && i_byte <= CH_F)) begin
            hex_v = i_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign is_oct  = (i_byte >= CH_0) && (i_byte <= CH_7);
    assign is_dec  = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign oct_acc = {r_digit[5:0], i_byte[2:0]};
    assign tacc    = esd_pkg::t_tacc'(r_time) * esd_pkg::t_tacc'(esd_pkg::DEC_BASE)
                   + esd_pkg::t_tacc'(i_byte[3:0]);

    always_comb begin
        n_mode   = r_mode;
        n_digit  = r_digit;
        n_dcount = r_dcount;
        n_time   = r_time;
        n_wait   = r_wait;
        bnd      = '0;
        ended    = 1'b0;
        rescan   = 1'b0;
        clr      = 1'b0;

        case (r_mode)
            M_ESC: begin
                n_mode = M_IDLE;
                case (i_byte)
                    CH_NUL: begin
                        bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_END, '0, '0, 1'b0);
                        bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
                        clr     = 1'b1;
                        ended   = 1'b1;
                    end
                    CH_X: begin
                        n_mode = M_HEX0;
                    end
                    CH_S: begin
                        bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_SEND, '0, '0, 1'b0);
                        bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
                    end
                    CH_D, CH_W: begin
                        n_mode = M_TIME;
                        n_time = '0;
                        n_wait = (i_byte == CH_W);
                    end
                    default: begin
                        if (is_oct) begin
                            n_mode   = M_OCT;
                            n_digit  = {6'd0, i_byte[2:0]};
                            n_dcount = 2'd1;
                        end else begin
                            bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_CHAR,
                                (i_byte == CH_A) ? C_BEL :
                                (i_byte == CH_B) ? C_BS  :
                                (i_byte == CH_F) ? C_FF  :
                                (i_byte == CH_N) ? C_LF  :
                                (i_byte == CH_R) ? C_CR  :
                                (i_byte == CH_T) ? C_HT  :
                                (i_byte == CH_V) ? C_VT  : i_byte, '0, 1'b0);
                            bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
                        end
                    end
                endcase
            end
            M_HEX0: begin
                if (hex_ok) begin
                    n_digit = {5'd0, hex_v};
                    n_mode  = M_HEX1;
                end else if (i_byte == CH_NUL) begin
                    bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_END, '0, '0, 1'b0);
                    bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
                    clr     = 1'b1;
                    ended   = 1'b1;
                end else begin
                    bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_CHAR, i_byte, '0, 1'b0);
                    bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
                    clr     = 1'b1;
                end
            end
            M_HEX1: begin
                if (hex_ok) begin
                    bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_CHAR,
                        {r_digit[3:0], hex_v}, '0, 1'b0);
                    bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
                    clr     = 1'b1;
                end else begin
                    bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_CHAR,
                        {4'd0, r_digit[3:0]}, '0, 1'b0);
                    bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
                    clr     = 1'b1;
                    rescan  = 1'b1;
                end
            end
            M_OCT: begin
                if (is_oct) begin
                    if (r_dcount >= 2'd2) begin
                        bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_CHAR,
                            oct_acc[7:0], '0, 1'b0);
                        bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
                        clr     = 1'b1;
                    end else begin
                        n_digit  = oct_acc;
                        n_dcount = r_dcount + 2'd1;
                    end
                end else begin
                    bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_CHAR,
                        r_digit[7:0], '0, 1'b0);
                    bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
                    clr     = 1'b1;
                    rescan  = 1'b1;
                end
            end
            M_TIME: begin
                if (is_dec) begin
                    if (tacc > esd_pkg::t_tacc'(esd_pkg::TIME_MAX)) begin
                        n_time = esd_pkg::TIME_MAX;
                    end else begin
                        n_time = tacc[esd_pkg::TIME_BITS-1:0];
                    end
                end else begin
                    // m suffix keeps milliseconds, anything else means seconds
                    bnd.toks[bnd.cnt] = esd_pkg::mk_tok(
                        r_wait ? esd_pkg::K_WAIT : esd_pkg::K_DELAY, '0, r_time,
                        i_byte != CH_M);
                    bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
                    clr     = 1'b1;
                    rescan  = (i_byte != CH_M) && (i_byte != CH_S);
                end
            end
            default: begin
                n_mode = M_IDLE;
                rescan = 1'b1;
            end
        endcase

        if (clr) begin
            n_mode   = M_IDLE;
            n_digit  = '0;
            n_dcount = '0;
            n_time   = '0;
            n_wait   = 1'b0;
        end

        // an idle byte, or one that closes an escape, is decoded as a plain byte
        if (rescan) begin
            if (i_byte == CH_NUL) begin
                bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_END, '0, '0, 1'b0);
                bnd.cnt  = bnd.cnt + esd_pkg::CNTW'(1);
                ended    = 1'b1;
                n_mode   = M_IDLE;
                n_digit  = '0;
                n_dcount = '0;
                n_time   = '0;
                n_wait   = 1'b0;
            end else if (i_byte == CH_BSL) begin
                n_mode = M_ESC;
            end else begin
                bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_CHAR, i_byte, '0, 1'b0);
                bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
            end
        end

        // flush a pending hex, octal or time value and close the string at its end
        if (!ended && i_last) begin
            if (n_mode == M_HEX1) begin
                bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_CHAR,
                    {4'd0, n_digit[3:0]}, '0, 1'b0);
                bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
            end else if (n_mode == M_OCT) begin
                bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_CHAR,
                    n_digit[7:0], '0, 1'b0);
                bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
            end else if (n_mode == M_TIME) begin
                bnd.toks[bnd.cnt] = esd_pkg::mk_tok(
                    n_wait ? esd_pkg::K_WAIT : esd_pkg::K_DELAY, '0, n_time, 1'b1);
                bnd.cnt = bnd.cnt + esd_pkg::CNTW'(1);
            end
            bnd.toks[bnd.cnt] = esd_pkg::mk_tok(esd_pkg::K_END, '0, '0, 1'b0);
            bnd.cnt  = bnd.cnt + esd_pkg::CNTW'(1);
            n_mode   = M_IDLE;
            n_digit  = '0;
            n_dcount = '0;
            n_time   = '0;
            n_wait   = 1'b0;
        end
    end

    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_digit  <= '0;
            r_dcount <= '0;
            r_time   <= '0;
            r_wait   <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_digit  <= n_digit;
            r_dcount <= n_dcount;
            r_time   <= n_time;
            r_wait   <= n_wait;
        end
    end

endmodule

FILE: hdl/esd_queue.sv
module esd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  esd_pkg::t_bundle i_data,
    output logic             o_full,
    output logic             o_valid,
    output esd_pkg::t_bundle o_data,
    input  logic             i_pop
);

    esd_pkg::t_bundle r_mem [esd_pkg::QDEPTH];
    esd_pkg::t_qptr   r_wp;
    esd_pkg::t_qptr   r_rp;
    esd_pkg::t_qcnt   r_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = (r_cnt == esd_pkg::t_qcnt'(esd_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + esd_pkg::t_qptr'(1);
            end
            if (rd) begin
                r_rp <= r_rp + esd_pkg::t_qptr'(1);
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + esd_pkg::t_qcnt'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - esd_pkg::t_qcnt'(1);
            end
        end
    end

endmodule

FILE: hdl/esd_back.sv
module esd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_bnd_valid,
    input  esd_pkg::t_bundle i_bnd,
    output logic             o_bnd_take,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_char_value,
    output logic [31:0]      o_millis,
    output logic             o_last_of_run
);

    esd_pkg::t_bundle r_cur;
    logic             r_cur_v;
    esd_pkg::t_cnt    r_idx;
    logic             r_out_v;
    logic [2:0]       r_kind;
    logic [7:0]       r_char;
    logic [31:0]      r_millis;
    logic             r_lastrun;

    esd_pkg::t_tok    tok;
    esd_pkg::t_time   v;
    esd_pkg::t_time   ms;
    logic             is_time;
    logic             cur_last;
    logic             out_load;

    assign tok      = r_cur.toks[r_idx];
    assign cur_last = (r_idx == r_cur.cnt - esd_pkg::CNTW'(1));
    assign out_load = r_cur_v && (!r_out_v || i_pop);
    assign o_bnd_take = i_bnd_valid && (!r_cur_v || (out_load && cur_last));

    // zero time means one, then optional seconds scaling
    always_comb begin
        is_time = (tok.kind == esd_pkg::K_DELAY) || (tok.kind == esd_pkg::K_WAIT);
        v       = (tok.tm == '0) ? esd_pkg::t_time'(1) : tok.tm;
        ms      = tok.scale ? esd_pkg::scale_ms(v) : v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v <= 1'b0;
            r_idx   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (o_bnd_take) begin
                r_cur_v <= 1'b1;
                r_idx   <= '0;
            end else if (out_load) begin
                r_idx <= r_idx + esd_pkg::CNTW'(1);
                if (cur_last) begin
                    r_cur_v <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_bnd_take) begin
            r_cur <= i_bnd;
        end
        if (out_load) begin
            r_kind    <= tok.kind;
            r_char    <= tok.ch;
            r_millis  <= is_time ? 32'(ms) : 32'd0;
            r_lastrun <= cur_last;
        end
    end

    assign o_empty       = !r_out_v;
    assign o_kind        = r_kind;
    assign o_char_value  = r_char;
    assign o_millis      = r_millis;
    assign o_last_of_run = r_lastrun;

endmodule

FILE: hdl/esd_check.sv
module esd_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_char_value,
    input logic [31:0] o_millis,
    input logic        o_last_of_run
);

    // a stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_kind) && $stable(o_char_value)
            && $stable(o_millis) && $stable(o_last_of_run))
        else $error("stalled token changed");

    // end of string closes the run of its byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == esd_pkg::K_END |-> o_last_of_run)
        else $error("end token not last of run");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind != esd_pkg::K_CHAR |-> o_char_value == 8'd0)
        else $error("char value on non-char token");

    // time tokens are never zero, other kinds carry no time
    a_millis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_kind == esd_pkg::K_DELAY || o_kind == esd_pkg::K_WAIT)
            ? (o_millis != 32'd0) : (o_millis == 32'd0)))
        else $error("bad millis");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("token after reset");

    // full only matters for pushes, kept visible for waveform debug
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full && !pop |=> full || !push || push)
        else $error("full check");

endmodule

bind escape_sequence_decoder esd_check u_esd_check (.*);

FILE: test/escape_sequence_decoder_test.sv
module escape_sequence_decoder_test;

    localparam int STALL_LIMIT = 4000;
    localparam int MAX_SHOWN   = 10;
    localparam logic [63:0] TIME_CAP = 64'(esd_pkg::TIME_MAX);

    typedef enum logic [3:0] {
        PM_IDLE, PM_ESC, PM_HEX0, PM_HEX1, PM_OCT, PM_TIME
    } t_parse_mode;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  ch;
        logic [31:0] ms;
        logic        fin;
    } t_token;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_byte_in;
    logic        i_is_last;
    logic        empty;
    logic        pop;
    logic [2:0]  o_kind;
    logic [7:0]  o_char_value;
    logic [31:0] o_millis;
    logic        o_last_of_run;

    // decoder state mirrored in the testbench
    t_parse_mode pmode;
    logic [8:0]  dig_acc;
    logic [1:0]  dig_cnt;
    logic [63:0] tm_acc;
    logic        wait_sel;

    t_token step_toks[esd_pkg::MAX_TOKS];
    int     step_n;
    t_token pending_tokens[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;
    int hold_left;
    int sent_bytes;
    int checked_tokens;
    int end_tokens;
    int time_tokens;
    int mismatches;
    int quiet_cycles;
    int full_stalls;

    escape_sequence_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_byte_in     (i_byte_in),
        .i_is_last     (i_is_last),
        .empty         (empty),
        .pop           (pop),
        .o_kind        (o_kind),
        .o_char_value  (o_char_value),
        .o_millis      (o_millis),
        .o_last_of_run (o_last_of_run)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ---------------- token prediction ----------------

    function automatic void clear_parse();
        pmode    = PM_IDLE;
        dig_acc  = '0;
        dig_cnt  = '0;
        tm_acc   = '0;
        wait_sel = 1'b0;
    endfunction

    function automatic void add_token(logic [2:0] kind, logic [7:0] ch, logic [31:0] ms);
        t_token t;
        t.kind = kind;
        t.ch   = ch;
        t.ms   = ms;
        t.fin  = 1'b0;
        step_toks[step_n] = t;
        step_n++;
    endfunction

    function automatic int hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        return -1;
    endfunction

    function automatic void add_time_token(bit in_seconds);
        logic [63:0] v;
        v = (tm_acc == 0) ? 64'd1 : tm_acc;
        if (v > TIME_CAP) v = TIME_CAP;
        if (in_seconds)
            v = (v > TIME_CAP / esd_pkg::MS_PER_S) ? TIME_CAP : v * esd_pkg::MS_PER_S;
        add_token(wait_sel ? esd_pkg::K_WAIT : esd_pkg::K_DELAY, 8'd0, v[31:0]);
    endfunction

    // returns 1 when the byte closed the string
    function automatic bit take_plain_byte(logic [7:0] b);
        if (b == 8'h00) begin
            add_token(esd_pkg::K_END, 8'd0, 32'd0);
            clear_parse();
            return 1'b1;
        end
        if (b == "\\") begin
            pmode = PM_ESC;
            return 1'b0;
        end
        add_token(esd_pkg::K_CHAR, b, 32'd0);
        return 1'b0;
    endfunction

    function automatic bit take_escape_letter(logic [7:0] b);
        pmode = PM_IDLE;
        case (b)
            8'h00: begin
                add_token(esd_pkg::K_END, 8'd0, 32'd0);
                clear_parse();
                return 1'b1;
            end
            "a": add_token(esd_pkg::K_CHAR, 8'd7, 32'd0);
            "b": add_token(esd_pkg::K_CHAR, 8'd8, 32'd0);
            "f": add_token(esd_pkg::K_CHAR, 8'd12, 32'd0);
            "n": add_token(esd_pkg::K_CHAR, 8'd10, 32'd0);
            "r": add_token(esd_pkg::K_CHAR, 8'd13, 32'd0);
            "t": add_token(esd_pkg::K_CHAR, 8'd9, 32'd0);
            "v": add_token(esd_pkg::K_CHAR, 8'd11, 32'd0);
            "x": pmode = PM_HEX0;
            "s": add_token(esd_pkg::K_SEND, 8'd0, 32'd0);
            "d", "w": begin
                pmode    = PM_TIME;
                tm_acc   = '0;
                wait_sel = (b == "w");
            end
            default: begin
                if (b >= "0" && b <= "7") begin
                    pmode   = PM_OCT;
                    dig_acc = {6'd0, b[2:0]};
                    dig_cnt = 2'd1;
                end else begin
                    add_token(esd_pkg::K_CHAR, b, 32'd0);
                end
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic fin);
        bit          ended;
        int          h;
        logic [63:0] d;
        ended  = 1'b0;
        step_n = 0;
        case (pmode)
            PM_ESC: ended = take_escape_letter(b);
            PM_HEX0: begin
                h = hex_digit(b);
                if (h >= 0) begin
                    dig_acc = 9'(h);
                    pmode   = PM_HEX1;
                end else if (b == 8'h00) begin
                    add_token(esd_pkg::K_END, 8'd0, 32'd0);
                    clear_parse();
                    ended = 1'b1;
                end else begin
                    // bare x swallows the byte once
                    add_token(esd_pkg::K_CHAR, b, 32'd0);
                    clear_parse();
                end
            end
            PM_HEX1: begin
                h = hex_digit(b);
                if (h >= 0) begin
                    add_token(esd_pkg::K_CHAR, {dig_acc[3:0], 4'(h)}, 32'd0);
                    clear_parse();
                end else begin
                    add_token(esd_pkg::K_CHAR, {4'd0, dig_acc[3:0]}, 32'd0);
                    clear_parse();
                    ended = take_plain_byte(b);
                end
            end
            PM_OCT: begin
                if (b >= "0" && b <= "7") begin
                    dig_acc = {dig_acc[5:0], b[2:0]};
                    dig_cnt++;
                    if (dig_cnt >= 2'd3) begin
                        add_token(esd_pkg::K_CHAR, dig_acc[7:0], 32'd0);
                        clear_parse();
                    end
                end else begin
                    add_token(esd_pkg::K_CHAR, dig_acc[7:0], 32'd0);
                    clear_parse();
                    ended = take_plain_byte(b);
                end
            end
            PM_TIME: begin
                if (b >= "0" && b <= "9") begin
                    d = 64'(b - "0");
                    if (tm_acc > TIME_CAP || tm_acc > (TIME_CAP - d) / esd_pkg::DEC_BASE)
                        tm_acc = TIME_CAP;
                    else
                        tm_acc = tm_acc * esd_pkg::DEC_BASE + d;
                end else if (b == "m") begin
                    add_time_token(1'b0);
                    clear_parse();
                end else begin
                    add_time_token(1'b1);
                    clear_parse();
                    if (b != "s") ended = take_plain_byte(b);
                end
            end
            default: begin
                pmode = PM_IDLE;
                ended = take_plain_byte(b);
            end
        endcase

        // last flag flushes a pending hex, octal or time value, then closes the string
        if (!ended && fin) begin
            if (pmode == PM_HEX1)
                add_token(esd_pkg::K_CHAR, {4'd0, dig_acc[3:0]}, 32'd0);
            else if (pmode == PM_OCT)
                add_token(esd_pkg::K_CHAR, dig_acc[7:0], 32'd0);
            else if (pmode == PM_TIME)
                add_time_token(1'b1);
            add_token(esd_pkg::K_END, 8'd0, 32'd0);
            clear_parse();
        end

        for (int i = 0; i < step_n; i++) begin
            step_toks[i].fin = (i == step_n - 1);
            pending_tokens.push_back(step_toks[i]);
        end
    endfunction

    // ---------------- input side ----------------

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_byte_in <= b;
        i_is_last <= fin;
        do @(posedge i_clk); while (full);
        decode_byte(b, fin);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input bit fin_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin_at_end && (i == s.len() - 1));
    endtask

    // one well-formed escape or plain byte, now and then noise
    task automatic send_random_segment();
        logic [7:0] seg[$];
        logic [7:0] b;
        int         pick;
        int         nd;
        string      ctl;
        string      hexc;
        ctl  = "abfnrtv";
        hexc = "0123456789abcdefABCDEF";
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            do b = 8'($urandom_range(1, 255)); while (b == "\\");
            seg.push_back(b);
        end else if (pick < 32) begin
            seg.push_back("\\");
            seg.push_back(ctl[$urandom_range(0, 6)]);
        end else if (pick < 44) begin
            seg.push_back("\\");
            seg.push_back("x");
            nd = $urandom_range(1, 2);
            repeat (nd) seg.push_back(hexc[$urandom_range(0, 21)]);
        end else if (pick < 56) begin
            seg.push_back("\\");
            nd = $urandom_range(1, 3);
            repeat (nd) seg.push_back(8'("0" + $urandom_range(0, 7)));
        end else if (pick < 61) begin
            seg.push_back("\\");
            seg.push_back("s");
        end else if (pick < 80) begin
            seg.push_back("\\");
            seg.push_back($urandom_range(0, 1) ? "w" : "d");
            // mostly short times, sometimes long enough to saturate
            nd = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 11) : $urandom_range(0, 4);
            repeat (nd) seg.push_back(8'("0" + $urandom_range(0, 9)));
            case ($urandom_range(0, 2))
                0: seg.push_back("m");
                1: seg.push_back("s");
                default: ;
            endcase
        end else if (pick < 86) begin
            seg.push_back("\\");
            seg.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 95) begin
            seg.push_back(8'($urandom_range(0, 255)));
        end else begin
            seg.push_back(8'h00);
        end
        foreach (seg[i]) send_byte(seg[i], $urandom_range(0, 99) < 6);
    endtask

    // ---------------- result side ----------------

    initial begin
        pop       = 1'b0;
        hold_req  = 0;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("ERROR: %s", msg);
    endfunction

    always @(posedge i_clk) begin : check_tokens
        t_token want;
        if (i_rst_n && pop && !empty) begin
            if (pending_tokens.size() == 0) begin
                flag_error($sformatf(
                    "unexpected token kind %0d char %02h ms %0d last %0b",
                    o_kind, o_char_value, o_millis, o_last_of_run));
            end else begin
                want = pending_tokens.pop_front();
                if (o_kind !== want.kind || o_char_value !== want.ch ||
                    o_millis !== want.ms || o_last_of_run !== want.fin)
                    flag_error($sformatf(
                        {"token %0d: expected kind %0d char %02h ms %0d last %0b, ",
                         "got kind %0d char %02h ms %0d last %0b"},
                        checked_tokens, want.kind, want.ch, want.ms, want.fin,
                        o_kind, o_char_value, o_millis, o_last_of_run));
                if (want.kind == esd_pkg::K_END) end_tokens++;
                if (want.kind == esd_pkg::K_DELAY || want.kind == esd_pkg::K_WAIT)
                    time_tokens++;
            end
            checked_tokens++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("escape_sequence_decoder test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (i_rst_n && push && full) full_stalls <= full_stalls + 1;
    end

    // ---------------- tests ----------------

    task automatic test_directed();
        send_text("\\x4F\\xg", 1'b0);
        send_text("\\777\\s", 1'b0);
        send_text("\\q\\d0m", 1'b0);
        send_text("\\w5000000", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("\\x7", 1'b1);
    endtask

    task automatic test_random(input int upto);
        while (sent_bytes < upto) send_random_segment();
    endtask

    // receiver stops for a long stretch while bytes keep coming
    task automatic test_receiver_holdoff();
        int saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_req      = 250;
        repeat (40) send_byte(8'($urandom_range(33, 91)), 1'b0);
        send_idle_pct = saved_idle;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_byte_in      = 8'd0;
        i_is_last      = 1'b0;
        send_idle_pct  = 25;
        recv_idle_pct  = 59;
        sent_bytes     = 0;
        checked_tokens = 0;
        end_tokens     = 0;
        time_tokens    = 0;
        mismatches     = 0;
        full_stalls    = 0;
        clear_parse();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(120);

        send_idle_pct = 59;
        recv_idle_pct = 25;
        test_receiver_holdoff();
        test_random(230);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(310);
        push <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("sent %0d bytes, checked %0d tokens (%0d string ends, %0d delay/wait)",
            sent_bytes, checked_tokens, end_tokens, time_tokens);
        $display("input held off by full on %0d cycles, %0d mismatches",
            full_stalls, mismatches);
        if (mismatches == 0)
            $display("escape_sequence_decoder test passed");
        else
            $display("escape_sequence_decoder test failed");
        $finish;
    end

endmodule
